// ===== src/pwm_motif_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// pwm_motif_scanner assertion macros
// Concurrent assertion forms used by the motif scanner sequencer.
// ----------------------------------------------------------------------------
`ifndef PWM_MOTIF_SCANNER_MACROS_SVH
`define PWM_MOTIF_SCANNER_MACROS_SVH

// same-cycle implication
`define PMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pms_pkg.sv =====
// ----------------------------------------------------------------------------
// pms_pkg
// Types, constants and base decoding for the motif scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

  localparam int MAX_MOTIF   = 32;
  localparam int NUM_COLS    = 5;
  localparam int WEIGHT_BITS = 16;
  localparam int POS_BITS    = 32;
  localparam int SCORE_W     = 21;
  localparam int CODE_W      = 3;
  localparam int ROW_W       = $clog2(MAX_MOTIF);
  localparam int LEN_W       = $clog2(MAX_MOTIF + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 21;
  localparam int BYTE_W      = 8;

  // column codes
  localparam logic [CODE_W-1:0] COL_A     = 3'd0;
  localparam logic [CODE_W-1:0] COL_C     = 3'd1;
  localparam logic [CODE_W-1:0] COL_G     = 3'd2;
  localparam logic [CODE_W-1:0] COL_T     = 3'd3;
  localparam logic [CODE_W-1:0] COL_OTHER = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 1'b1;

  // characters
  localparam logic [BYTE_W-1:0] CH_A_LO = 8'h61;
  localparam logic [BYTE_W-1:0] CH_A_UP = 8'h41;
  localparam logic [BYTE_W-1:0] CH_C_LO = 8'h63;
  localparam logic [BYTE_W-1:0] CH_C_UP = 8'h43;
  localparam logic [BYTE_W-1:0] CH_G_LO = 8'h67;
  localparam logic [BYTE_W-1:0] CH_G_UP = 8'h47;
  localparam logic [BYTE_W-1:0] CH_T_LO = 8'h74;
  localparam logic [BYTE_W-1:0] CH_T_UP = 8'h54;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_BASE    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_ACCUM,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic win_shift;
    logic win_clear;
    logic scan_load;
    logic scan_shift;
    logic acc_en;
    logic wr_en;
  } cell_ctrl_t;

  function automatic logic [CODE_W-1:0] base_code(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] code;
    unique case (b)
      CH_A_LO, CH_A_UP: code = COL_A;
      CH_C_LO, CH_C_UP: code = COL_C;
      CH_G_LO, CH_G_UP: code = COL_G;
      CH_T_LO, CH_T_UP: code = COL_T;
      default:          code = COL_OTHER;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== src/pms_cell.sv =====
// ----------------------------------------------------------------------------
// pms_cell
// One matrix row: weight row, window slot, scan slot and partial sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_cell (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pms_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic                               wr_sel_i,
  input  wire logic [pms_pkg::CODE_W-1:0]         wr_col_i,
  input  wire logic [pms_pkg::WEIGHT_BITS-1:0]    wr_value_i,
  input  wire logic [pms_pkg::CODE_W-1:0]         win_i,
  input  wire logic [pms_pkg::CODE_W-1:0]         scan_load_i,
  input  wire logic [pms_pkg::CODE_W-1:0]         scan_i,
  input  wire logic [pms_pkg::SCORE_W-1:0]        sum_i,
  output logic      [pms_pkg::CODE_W-1:0]         win_o,
  output logic      [pms_pkg::CODE_W-1:0]         scan_o,
  output logic      [pms_pkg::SCORE_W-1:0]        sum_o
);

  logic [pms_pkg::WEIGHT_BITS-1:0] w_q [pms_pkg::NUM_COLS];
  logic [pms_pkg::CODE_W-1:0]      win_q;
  logic [pms_pkg::CODE_W-1:0]      scan_q;
  logic [pms_pkg::SCORE_W-1:0]     sum_q;
  logic [pms_pkg::WEIGHT_BITS-1:0] sel_w;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < pms_pkg::NUM_COLS; k++) begin
      if (ctrl_i.wr_en && wr_sel_i && (wr_col_i == pms_pkg::CODE_W'(k))) begin
        w_q[k] <= wr_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.win_clear) begin
      win_q <= '0;
    end else if (ctrl_i.win_shift) begin
      win_q <= win_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_load) begin
      scan_q <= scan_load_i;
    end else if (ctrl_i.scan_shift) begin
      scan_q <= scan_i;
    end
  end

  always_comb begin
    if (scan_q < pms_pkg::COL_OTHER) begin
      sel_w = w_q[scan_q];
    end else begin
      sel_w = w_q[pms_pkg::COL_OTHER];
    end
  end

  // add this row's term to the partial sum handed up from the row below
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      sum_q <= sum_i + {{(pms_pkg::SCORE_W - pms_pkg::WEIGHT_BITS){sel_w[pms_pkg::WEIGHT_BITS-1]}},
                        sel_w};
    end
  end

  assign win_o  = win_q;
  assign scan_o = scan_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

// ===== src/pms_ctrl.sv =====
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer: accepts items, runs the align and accumulate passes, loads the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_motif_scanner_macros.svh"

module pms_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire pms_pkg::cmd_e                cmd_i,
  input  wire logic [pms_pkg::LEN_W-1:0]    len_i,
  input  wire logic                         hit_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  output logic                              in_ready_o,
  output pms_pkg::cell_ctrl_t               cell_ctrl_o,
  output logic                              out_load_o,
  output logic [pms_pkg::LEN_W-1:0]         len_o
);

  pms_pkg::state_e             state_q, state_d;
  logic [pms_pkg::LEN_W-1:0]   step_q, step_d;
  logic [pms_pkg::LEN_W-1:0]   len_q, len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pms_pkg::ST_IDLE;
      step_q  <= '0;
      len_q   <= pms_pkg::LEN_W'(1);
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    len_d       = len_q;
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    cell_ctrl_o = '0;
    unique case (state_q)
      pms_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (cmd_i)
            pms_pkg::CMD_WRITE: cell_ctrl_o.wr_en = 1'b1;
            pms_pkg::CMD_BASE: begin
              cell_ctrl_o.win_shift = 1'b1;
              cell_ctrl_o.scan_load = 1'b1;
              len_d = len_i;
              if (len_i == pms_pkg::LEN_W'(pms_pkg::MAX_MOTIF)) begin
                state_d = pms_pkg::ST_ACCUM;
                step_d  = len_i;
              end else begin
                state_d = pms_pkg::ST_ALIGN;
                step_d  = pms_pkg::LEN_W'(pms_pkg::MAX_MOTIF) - len_i;
              end
            end
            pms_pkg::CMD_RESTART: cell_ctrl_o.win_clear = 1'b1;
            pms_pkg::CMD_NOP: ;
            default: ;
          endcase
        end
      end
      pms_pkg::ST_ALIGN: begin
        // slide the scan row down until row j sees the matching base
        cell_ctrl_o.scan_shift = 1'b1;
        step_d = step_q - pms_pkg::LEN_W'(1);
        if (step_q == pms_pkg::LEN_W'(1)) begin
          state_d = pms_pkg::ST_ACCUM;
          step_d  = len_q;
        end
      end
      pms_pkg::ST_ACCUM: begin
        cell_ctrl_o.acc_en = 1'b1;
        step_d = step_q - pms_pkg::LEN_W'(1);
        if (step_q == pms_pkg::LEN_W'(1)) begin
          state_d = pms_pkg::ST_FINISH;
        end
      end
      pms_pkg::ST_FINISH: begin
        // hold while an earlier hit still waits to be taken
        if (!hit_i) begin
          state_d = pms_pkg::ST_IDLE;
        end else if (!out_valid_i || out_ready_i) begin
          out_load_o = 1'b1;
          state_d    = pms_pkg::ST_IDLE;
        end
      end
      default: state_d = pms_pkg::ST_IDLE;
    endcase
  end

  assign len_o = len_q;

  `PMS_ASSERT_IMPLY(a_step_live, clk_i, rst_ni, (state_q == pms_pkg::ST_ALIGN || state_q == pms_pkg::ST_ACCUM), (step_q != '0), "pass counter ran out")
  `PMS_ASSERT_NEXT(a_base_busy, clk_i, rst_ni, (in_valid_i && in_ready_o && cmd_i == pms_pkg::CMD_BASE), (state_q == pms_pkg::ST_ALIGN || state_q == pms_pkg::ST_ACCUM), "base transfer did not start a pass")
  `PMS_ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, out_load_o, (!out_valid_i || out_ready_i), "pending hit overwritten")

endmodule

`default_nettype wire

// ===== src/pwm_motif_scanner.sv =====
// ----------------------------------------------------------------------------
// pwm_motif_scanner
// Position weight matrix scan of a DNA byte stream over a row of cells.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   command, weight row/column/value, base byte
//   out      output     out_valid_o / out_ready_i hit_position, hit_score
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// Weight writes, restarts and unused commands act at transfer and start no pass.
// A base item runs as a transfer, shifts that line the scan row up with the
// matrix rows (none when motif_length is 32), steps of the partial sum
// rippling up the cell row, and a final state to compare and load the output.
// The output register holds a hit while the next items are taken; the block
// waits in its last pass cycle only when a new hit meets an untaken one.
// Reset clears the window, the base count and the output valid flag and sets
// the sequencer and configuration to defaults; weights are undefined until written.
`default_nettype none

module pwm_motif_scanner (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        command_i,
  input  wire logic [pms_pkg::ROW_W-1:0]         weight_row_i,
  input  wire logic [pms_pkg::CODE_W-1:0]        weight_column_i,
  input  wire logic signed [pms_pkg::WEIGHT_BITS-1:0] weight_value_i,
  input  wire logic [pms_pkg::BYTE_W-1:0]        base_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [pms_pkg::POS_BITS-1:0]           hit_position_o,
  output logic signed [pms_pkg::SCORE_W-1:0]     hit_score_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [pms_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pms_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int M = pms_pkg::MAX_MOTIF;

  pms_pkg::cell_ctrl_t              cell_ctrl;
  pms_pkg::cmd_e                    cmd;
  logic                             out_load;
  logic                             hit;
  logic                             base_xfer;
  logic                             restart_xfer;
  logic [pms_pkg::LEN_W-1:0]        len_eff;
  logic [pms_pkg::LEN_W-1:0]        len_run;
  logic [pms_pkg::ROW_W-1:0]        tap;
  logic [pms_pkg::CODE_W-1:0]       new_code;
  logic [pms_pkg::SCORE_W-1:0]      score;
  logic [pms_pkg::POS_BITS-1:0]     seen_inc;

  logic [pms_pkg::LEN_W-1:0]        cfg_len_q;
  logic [pms_pkg::SCORE_W-1:0]      cfg_thr_q;
  logic [pms_pkg::SCORE_W-1:0]      thr_q;
  logic [pms_pkg::POS_BITS-1:0]     seen_q;
  logic [pms_pkg::POS_BITS-1:0]     pos_q;
  logic                             enough_q;
  logic                             out_valid_q;
  logic [pms_pkg::POS_BITS-1:0]     out_pos_q;
  logic [pms_pkg::SCORE_W-1:0]      out_score_q;

  logic [pms_pkg::CODE_W-1:0]       win_w       [M];
  logic [pms_pkg::CODE_W-1:0]       win_in_w    [M];
  logic [pms_pkg::CODE_W-1:0]       scan_w      [M];
  logic [pms_pkg::CODE_W-1:0]       scan_in_w   [M];
  logic [pms_pkg::CODE_W-1:0]       scan_ld_w   [M];
  logic [pms_pkg::SCORE_W-1:0]      sum_w       [M];
  logic [pms_pkg::SCORE_W-1:0]      sum_in_w    [M];
  logic                             wr_sel_w    [M];

  assign cmd      = pms_pkg::cmd_e'(command_i);
  assign new_code = pms_pkg::base_code(base_byte_i);

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= pms_pkg::LEN_W'(1);
      cfg_thr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pms_pkg::CFG_MOTIF_LENGTH:    cfg_len_q <= cfg_data_i[pms_pkg::LEN_W-1:0];
        pms_pkg::CFG_SCORE_THRESHOLD: cfg_thr_q <= cfg_data_i[pms_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_len_q == '0) begin
      len_eff = pms_pkg::LEN_W'(1);
    end else if (cfg_len_q > pms_pkg::LEN_W'(M)) begin
      len_eff = pms_pkg::LEN_W'(M);
    end else begin
      len_eff = cfg_len_q;
    end
  end

  // ---- sequencer ----
  pms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd),
    .len_i       (len_eff),
    .hit_i       (hit),
    .out_valid_i (out_valid_q),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .cell_ctrl_o (cell_ctrl),
    .out_load_o  (out_load),
    .len_o       (len_run)
  );

  assign base_xfer    = in_valid_i && in_ready_o && (cmd == pms_pkg::CMD_BASE);
  assign restart_xfer = in_valid_i && in_ready_o && (cmd == pms_pkg::CMD_RESTART);

  // ---- base count and hit position ----
  always_comb begin
    if (seen_q == '1) begin
      seen_inc = seen_q;
    end else begin
      seen_inc = seen_q + pms_pkg::POS_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      enough_q <= 1'b0;
    end else if (restart_xfer) begin
      seen_q   <= '0;
    end else if (base_xfer) begin
      seen_q   <= seen_inc;
      enough_q <= seen_inc >= pms_pkg::POS_BITS'(len_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_xfer) begin
      pos_q <= seen_inc - pms_pkg::POS_BITS'(len_eff);
      thr_q <= cfg_thr_q;
    end
  end

  // ---- cell row ----
  for (genvar c = 0; c < M; c++) begin : g_cell
    if (c == 0) begin : g_first
      assign win_in_w[c] = new_code;
      assign sum_in_w[c] = '0;
    end else begin : g_rest
      assign win_in_w[c] = win_w[c-1];
      assign sum_in_w[c] = sum_w[c-1];
    end
    // scan row loads the shifted window in reverse order
    if (c == M - 1) begin : g_top
      assign scan_ld_w[c] = new_code;
      assign scan_in_w[c] = pms_pkg::COL_A;
    end else begin : g_mid
      assign scan_ld_w[c] = win_w[M-2-c];
      assign scan_in_w[c] = scan_w[c+1];
    end
    assign wr_sel_w[c] = (weight_row_i == pms_pkg::ROW_W'(c));

    pms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .wr_sel_i    (wr_sel_w[c]),
      .wr_col_i    (weight_column_i),
      .wr_value_i  (weight_value_i),
      .win_i       (win_in_w[c]),
      .scan_load_i (scan_ld_w[c]),
      .scan_i      (scan_in_w[c]),
      .sum_i       (sum_in_w[c]),
      .win_o       (win_w[c]),
      .scan_o      (scan_w[c]),
      .sum_o       (sum_w[c])
    );
  end

  // ---- score tap and compare ----
  assign tap   = pms_pkg::ROW_W'(len_run - pms_pkg::LEN_W'(1));
  assign score = sum_w[tap];
  assign hit   = enough_q && ($signed(score) > $signed(thr_q));

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q   <= pos_q;
      out_score_q <= score;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_position_o = out_pos_q;
  assign hit_score_o    = out_score_q;

endmodule

`default_nettype wire
